[hdl/ecpi_pkg.sv]
// Shared types and constants for the exact color palette indexer.
package ecpi_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int CODE_W        = 8;
    localparam int COLOR_W       = 24;
    localparam int DATA_W        = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CODE_W-1:0]     TRANSP_CODE_RESET = CODE_W'(255);
    localparam logic [PADDR_W-1:0]    ADDR_TRANSP_CODE  = PADDR_W'(0);
    localparam logic [CNT_W-1:0]      DEPTH_COUNT       = CNT_W'(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        RES_TRANSP = 2'd0,
        RES_HIT    = 2'd1,
        RES_MISS   = 2'd2
    } ecpi_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      rd;
        logic      step;
        logic      fin;
        ecpi_res_t kind;
    } ecpi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic transp;
        logic used_zero;
        logic match;
        logic last;
        logic out_busy;
    } ecpi_stat_t;

endpackage

[hdl/exact_color_palette_indexer_core.sv]
// Top level of the exact color palette indexer: stream ports, APB port, controller and datapath.
//
// Each pixel is taken in, then its RGB value is compared against the palette entries in use,
// one entry at a time through the single registered read port of the 64-entry palette
// memory, each entry read in ST_READ and compared in ST_CMP. A transparent pixel or a pixel
// meeting an empty palette skips the search; otherwise the search stops at the first match,
// or after all entries in use when nothing matches. The result is registered before m_tvalid
// rises. One pixel is in work at a time; the next pixel is accepted as soon as the previous
// result sits in the output register, even while that result still waits for m_tready. The
// palette memory needs no clearing after reset: only entries written since reset or the last
// frame start are ever compared.
module exact_color_palette_indexer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ecpi_pkg::DATA_W-1:0]     s_tdata,   // red, green, blue, alpha
    input  logic [0:0]                      s_tuser,   // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ecpi_pkg::DATA_W-1:0]     m_tdata,   // code, new_color
    output logic [1:0]                      m_tuser,   // overflow, new_entry
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ecpi_pkg::PADDR_W-1:0]    paddr,
    input  logic [ecpi_pkg::PDATA_W-1:0]    pwdata,
    output logic [ecpi_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import ecpi_pkg::*;

    ecpi_cmd_t          cmd;
    ecpi_stat_t         stat;
    logic [CODE_W-1:0]  out_code;
    logic               out_overflow;
    logic               out_new_entry;
    logic [COLOR_W-1:0] out_new_color;
    logic               cfg_we;
    logic [CODE_W-1:0]  transp_code;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_TRANSP_CODE);
    assign prdata = (paddr == ADDR_TRANSP_CODE) ? PDATA_W'(transp_code) : '0;

    ecpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ecpi_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_data         (s_tdata),
        .in_frame_start  (s_tuser[0]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_code        (out_code),
        .out_overflow    (out_overflow),
        .out_new_entry   (out_new_entry),
        .out_new_color   (out_new_color),
        .cfg_we          (cfg_we),
        .cfg_wdata       (pwdata[CODE_W-1:0]),
        .cfg_transp_code (transp_code)
    );

    assign m_tdata = {out_new_color, out_code};
    assign m_tuser = {out_new_entry, out_overflow};

endmodule

[hdl/ecpi_ctrl.sv]
// Controller state machine: sequences capture, palette search and result load.
module ecpi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ecpi_pkg::ecpi_stat_t stat,
    output ecpi_pkg::ecpi_cmd_t  cmd
);
    import ecpi_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CMP    = 5'b01000,
        ST_FINISH = 5'b10000
    } ecpi_state_t;

    ecpi_state_t state_reg, state_next;
    ecpi_res_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= RES_TRANSP;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.load   = 1'b0;
        cmd.rd     = 1'b0;
        cmd.step   = 1'b0;
        cmd.fin    = 1'b0;
        cmd.kind   = kind_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (stat.transp)
                begin
                    kind_next  = RES_TRANSP;
                    state_next = ST_FINISH;
                end
                else if (stat.used_zero)
                begin
                    kind_next  = RES_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (stat.match)
                begin
                    kind_next  = RES_HIT;
                    state_next = ST_FINISH;
                end
                else if (stat.last)
                begin
                    kind_next  = RES_MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/ecpi_dp.sv]
// Datapath: pixel capture, palette memory, search index, result register, config.
module ecpi_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ecpi_pkg::ecpi_cmd_t            cmd,
    output ecpi_pkg::ecpi_stat_t           stat,
    input  logic [ecpi_pkg::DATA_W-1:0]    in_data,
    input  logic                           in_frame_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ecpi_pkg::CODE_W-1:0]    out_code,
    output logic                           out_overflow,
    output logic                           out_new_entry,
    output logic [ecpi_pkg::COLOR_W-1:0]   out_new_color,
    input  logic                           cfg_we,
    input  logic [ecpi_pkg::CODE_W-1:0]    cfg_wdata,
    output logic [ecpi_pkg::CODE_W-1:0]    cfg_transp_code
);
    import ecpi_pkg::*;

    logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

    logic [COLOR_W-1:0] color_reg;
    logic               transp_reg;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COLOR_W-1:0] rd_data_reg;
    logic [CODE_W-1:0]  tcode_reg;

    logic               oval_reg, oval_next;
    logic [CODE_W-1:0]  ocode_reg, ocode_next;
    logic               oovf_reg, oovf_next;
    logic               onew_reg, onew_next;
    logic [COLOR_W-1:0] ocolor_reg, ocolor_next;

    logic               full;
    logic               append;
    logic [COLOR_W-1:0] in_color;

    // red sits lowest on the bus, highest in the packed color
    assign in_color = {in_data[7:0], in_data[15:8], in_data[23:16]};
    assign full     = (used_reg == DEPTH_COUNT);
    assign append   = cmd.fin && (cmd.kind == RES_MISS) && !full;

    assign stat.transp    = transp_reg;
    assign stat.used_zero = (used_reg == '0);
    assign stat.match     = (rd_data_reg == color_reg);
    assign stat.last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign stat.out_busy  = oval_reg && !out_ready;

    always_comb
    begin
        used_next = used_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            if (in_frame_start)
            begin
                used_next = '0;
            end
            idx_next = '0;
        end
        if (cmd.step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (append)
        begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        oval_next   = oval_reg;
        ocode_next  = ocode_reg;
        oovf_next   = oovf_reg;
        onew_next   = onew_reg;
        ocolor_next = ocolor_reg;
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        if (cmd.fin)
        begin
            oval_next   = 1'b1;
            oovf_next   = 1'b0;
            onew_next   = 1'b0;
            ocolor_next = '0;
            unique case (cmd.kind)
                RES_TRANSP:
                begin
                    ocode_next = tcode_reg;
                end
                RES_HIT:
                begin
                    ocode_next = CODE_W'(idx_reg);
                end
                RES_MISS:
                begin
                    if (full)
                    begin
                        ocode_next = '0;
                        oovf_next  = 1'b1;
                    end
                    else
                    begin
                        ocode_next  = CODE_W'(used_reg);
                        onew_next   = 1'b1;
                        ocolor_next = color_reg;
                    end
                end
                default:
                begin
                    ocode_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
            tcode_reg <= TRANSP_CODE_RESET;
        end
        else
        begin
            used_reg <= used_next;
            idx_reg  <= idx_next;
            oval_reg <= oval_next;
            if (cfg_we)
            begin
                tcode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            color_reg  <= in_color;
            transp_reg <= (in_data[31:24] == 8'd0);
        end
        ocode_reg  <= ocode_next;
        oovf_reg   <= oovf_next;
        onew_reg   <= onew_next;
        ocolor_reg <= ocolor_next;
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            palette_mem[used_reg[IDX_W-1:0]] <= color_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= palette_mem[idx_reg];
        end
    end

    assign out_valid       = oval_reg;
    assign out_code        = ocode_reg;
    assign out_overflow    = oovf_reg;
    assign out_new_entry   = onew_reg;
    assign out_new_color   = ocolor_reg;
    assign cfg_transp_code = tcode_reg;

endmodule

[hdl/ecpi_checker.sv]
// Port-level checker for the exact color palette indexer, bound to the top level.
module ecpi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ecpi_pkg::DATA_W-1:0] m_tdata,
    input logic [1:0]                  m_tuser
);
    import ecpi_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one pixel in work at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("overflow and new entry together");

    a_color_only_on_new: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[DATA_W-1:CODE_W] == '0)
        else $error("new color set without new entry");

    a_overflow_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[CODE_W-1:0] == '0)
        else $error("nonzero code on overflow");

endmodule

bind exact_color_palette_indexer_core ecpi_checker u_ecpi_checker (.*);
